/* src/prst_pkg.sv */
package prst_pkg;

   localparam int ANGLE_BITS = 12;
   localparam int QUAD_BITS  = ANGLE_BITS - 2;
   localparam int QUARTER    = 1 << QUAD_BITS;
   localparam int TRIG_BITS  = 17;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [1:0] QUAD_0 = 2'd0;
   localparam logic [1:0] QUAD_1 = 2'd1;
   localparam logic [1:0] QUAD_2 = 2'd2;
   localparam logic [1:0] QUAD_3 = 2'd3;

   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] SIN_DIV [0:7] = '{64'd6, 64'd20, 64'd42, 64'd72,
                                              64'd110, 64'd156, 64'd210, 64'd272};
   localparam logic [63:0] COS_DIV [0:7] = '{64'd2, 64'd12, 64'd30, 64'd56,
                                              64'd90, 64'd132, 64'd182, 64'd240};

   typedef struct packed {
      logic [1:0]           quad;
      logic [QUAD_BITS-1:0] idx;
      logic signed [31:0]   x;
      logic signed [31:0]   y;
      logic signed [31:0]   kx;
      logic signed [31:0]   ky;
      logic signed [31:0]   ox;
      logic signed [31:0]   oy;
   } queue_entry_type;

   typedef logic [2*TRIG_BITS-1:0] trig_rom_type [0:QUARTER-1];

   // quarter-wave sine and cosine, Taylor series in Q30 rounded to Q1.16
   function automatic trig_rom_type trig_rom_build();
      trig_rom_type      tab;
      logic [63:0]       t;
      logic [63:0]       t2;
      logic [63:0]       st;
      logic [63:0]       ct;
      logic signed [63:0] s;
      logic signed [63:0] c;
      logic [63:0]       rs;
      logic [63:0]       rc;
      for (int r = 0; r < QUARTER; r++) begin
         t  = (64'(r) * HALF_PI_Q30) >> QUAD_BITS;
         t2 = (t * t) >> 30;
         st = t;
         ct = 64'd1 << 30;
         s  = signed'(st);
         c  = signed'(ct);
         for (int k = 1; k <= 8; k++) begin
            st = ((st * t2) >> 30) / SIN_DIV[k-1];
            ct = ((ct * t2) >> 30) / COS_DIV[k-1];
            if ((k % 2) == 1) begin
               s = s - signed'(st);
               c = c - signed'(ct);
            end else begin
               s = s + signed'(st);
               c = c + signed'(ct);
            end
         end
         if (s < 0) begin
            s = 64'sd0;
         end
         if (c < 0) begin
            c = 64'sd0;
         end
         rs = (unsigned'(s) + 64'd8192) >> 14;
         rc = (unsigned'(c) + 64'd8192) >> 14;
         if (rs > 64'd65536) begin
            rs = 64'd65536;
         end
         if (rc > 64'd65536) begin
            rc = 64'd65536;
         end
         tab[r] = {rs[TRIG_BITS-1:0], rc[TRIG_BITS-1:0]};
      end
      return tab;
   endfunction

   localparam trig_rom_type TRIG_ROM = trig_rom_build();

endpackage

/* src/prst_front.sv */
module prst_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic signed [31:0]          req_point_x,
   input  logic signed [31:0]          req_point_y,
   input  logic [prst_pkg::ANGLE_BITS-1:0] req_rot_angle,
   input  logic signed [31:0]          req_scale_x,
   input  logic signed [31:0]          req_scale_y,
   input  logic signed [31:0]          req_offset_x,
   input  logic signed [31:0]          req_offset_y,
   output logic                        q_valid,
   output prst_pkg::queue_entry_type   q_entry,
   input  logic                        q_pop
);
   import prst_pkg::*;

   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   queue_entry_type       entry_ff [0:QUEUE_DEPTH-1];
   queue_entry_type       push_entry;
   logic [PTR_BITS-1:0]   wr_ptr_ff;
   logic [PTR_BITS-1:0]   wr_ptr_in;
   logic [PTR_BITS-1:0]   rd_ptr_ff;
   logic [PTR_BITS-1:0]   rd_ptr_in;
   logic [CNT_BITS-1:0]   count_ff;
   logic [CNT_BITS-1:0]   count_in;
   logic                  push;

   assign req_stall = (count_ff == CNT_BITS'(QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign q_valid   = (count_ff != '0);
   assign q_entry   = entry_ff[rd_ptr_ff];

   // classify: split angle into quadrant and table index
   always_comb begin
      push_entry.quad = req_rot_angle[ANGLE_BITS-1 -: 2];
      push_entry.idx  = req_rot_angle[QUAD_BITS-1:0];
      push_entry.x    = req_point_x;
      push_entry.y    = req_point_y;
      push_entry.kx   = req_scale_x;
      push_entry.ky   = req_scale_y;
      push_entry.ox   = req_offset_x;
      push_entry.oy   = req_offset_y;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (q_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !q_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && q_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_entry;
      end
   end

`ifndef ASSERT_OFF
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(QUEUE_DEPTH))
      else $error("queue count out of range");
   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> q_valid)
      else $error("pop from empty queue");
   a_count_up: assert property (@(posedge clock) disable iff (reset)
      (push && !q_pop) |=> count_ff == $past(count_ff) + 1'b1)
      else $error("queue count did not grow on push");
`endif

endmodule

/* src/prst_back.sv */
module prst_back (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      q_valid,
   input  prst_pkg::queue_entry_type q_entry,
   output logic                      q_pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic signed [31:0]        rsp_result_x,
   output logic signed [31:0]        rsp_result_y,
   output logic                      rsp_overflow
);
   import prst_pkg::*;

   localparam logic signed [51:0] SAT_MAX = 52'sd2147483647;
   localparam logic signed [51:0] SAT_MIN = -52'sd2147483648;

   typedef struct packed {
      logic signed [31:0] kx;
      logic signed [31:0] ky;
      logic signed [31:0] ox;
      logic signed [31:0] oy;
   } scale_type;

   logic adv;

   // stage 1: table read
   logic                 v1_ff;
   logic [1:0]           quad1_ff;
   logic [TRIG_BITS-1:0] sin1_ff;
   logic [TRIG_BITS-1:0] cos1_ff;
   logic signed [31:0]   x1_ff;
   logic signed [31:0]   y1_ff;
   scale_type            sc1_ff;

   // stage 2: quadrant folding
   logic                 v2_ff;
   logic signed [17:0]   sn2_in;
   logic signed [17:0]   cs2_in;
   logic signed [17:0]   sn2_ff;
   logic signed [17:0]   cs2_ff;
   logic signed [31:0]   x2_ff;
   logic signed [31:0]   y2_ff;
   scale_type            sc2_ff;
   logic signed [17:0]   s_pos;
   logic signed [17:0]   c_pos;

   // stage 3: rotation products
   logic                 v3_ff;
   logic signed [49:0]   pxc3_ff;
   logic signed [49:0]   pys3_ff;
   logic signed [49:0]   pxs3_ff;
   logic signed [49:0]   pyc3_ff;
   scale_type            sc3_ff;

   // stage 4: rotated point
   logic                 v4_ff;
   logic signed [34:0]   xr4_ff;
   logic signed [34:0]   yr4_ff;
   scale_type            sc4_ff;

   // stage 5: scale products
   logic                 v5_ff;
   logic signed [66:0]   mx5_ff;
   logic signed [66:0]   my5_ff;
   logic signed [31:0]   ox5_ff;
   logic signed [31:0]   oy5_ff;

   // output register
   logic                 rsp_valid_ff;
   logic signed [31:0]   rx_ff;
   logic signed [31:0]   ry_ff;
   logic                 ovf_ff;
   logic signed [51:0]   sum_x;
   logic signed [51:0]   sum_y;
   logic signed [31:0]   rx_in;
   logic signed [31:0]   ry_in;
   logic                 ovf_in;

   assign adv   = !(rsp_valid_ff && rsp_stall);
   assign q_pop = q_valid && adv;

   assign s_pos = $signed({1'b0, sin1_ff});
   assign c_pos = $signed({1'b0, cos1_ff});

   always_comb begin
      case (quad1_ff)
         QUAD_0: begin
            sn2_in = s_pos;
            cs2_in = c_pos;
         end
         QUAD_1: begin
            sn2_in = c_pos;
            cs2_in = -s_pos;
         end
         QUAD_2: begin
            sn2_in = -s_pos;
            cs2_in = -c_pos;
         end
         QUAD_3: begin
            sn2_in = -c_pos;
            cs2_in = s_pos;
         end
         default: begin
            sn2_in = s_pos;
            cs2_in = c_pos;
         end
      endcase
   end

   always_comb begin
      sum_x = 52'($signed(mx5_ff[66:16])) + 52'(ox5_ff);
      sum_y = 52'($signed(my5_ff[66:16])) + 52'(oy5_ff);
      ovf_in = 1'b0;
      if (sum_x > SAT_MAX) begin
         rx_in  = 32'sh7fffffff;
         ovf_in = 1'b1;
      end else if (sum_x < SAT_MIN) begin
         rx_in  = 32'sh80000000;
         ovf_in = 1'b1;
      end else begin
         rx_in = sum_x[31:0];
      end
      if (sum_y > SAT_MAX) begin
         ry_in  = 32'sh7fffffff;
         ovf_in = 1'b1;
      end else if (sum_y < SAT_MIN) begin
         ry_in  = 32'sh80000000;
         ovf_in = 1'b1;
      end else begin
         ry_in = sum_y[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         v1_ff        <= q_valid;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         v5_ff        <= v4_ff;
         rsp_valid_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         {sin1_ff, cos1_ff} <= TRIG_ROM[q_entry.idx];
         quad1_ff  <= q_entry.quad;
         x1_ff     <= q_entry.x;
         y1_ff     <= q_entry.y;
         sc1_ff.kx <= q_entry.kx;
         sc1_ff.ky <= q_entry.ky;
         sc1_ff.ox <= q_entry.ox;
         sc1_ff.oy <= q_entry.oy;

         sn2_ff <= sn2_in;
         cs2_ff <= cs2_in;
         x2_ff  <= x1_ff;
         y2_ff  <= y1_ff;
         sc2_ff <= sc1_ff;

         pxc3_ff <= x2_ff * cs2_ff;
         pys3_ff <= y2_ff * sn2_ff;
         pxs3_ff <= x2_ff * (-sn2_ff);
         pyc3_ff <= y2_ff * cs2_ff;
         sc3_ff  <= sc2_ff;

         xr4_ff <= 35'($signed(pxc3_ff[49:16])) + 35'($signed(pys3_ff[49:16]));
         yr4_ff <= 35'($signed(pxs3_ff[49:16])) + 35'($signed(pyc3_ff[49:16]));
         sc4_ff <= sc3_ff;

         mx5_ff <= xr4_ff * sc4_ff.kx;
         my5_ff <= yr4_ff * sc4_ff.ky;
         ox5_ff <= sc4_ff.ox;
         oy5_ff <= sc4_ff.oy;

         rx_ff  <= rx_in;
         ry_ff  <= ry_in;
         ovf_ff <= ovf_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_result_x = rx_ff;
   assign rsp_result_y = ry_ff;
   assign rsp_overflow = ovf_ff;

`ifndef ASSERT_OFF
   a_frozen: assert property (@(posedge clock) disable iff (reset)
      !adv |=> $stable(v1_ff) && $stable(v5_ff))
      else $error("pipeline moved while output held");
   a_last_stage: assert property (@(posedge clock) disable iff (reset)
      (adv && v5_ff) |=> rsp_valid_ff)
      else $error("item lost at output register");
   a_pop_feeds: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> v1_ff)
      else $error("popped item did not enter pipeline");
`endif

endmodule

/* src/point_rotate_scale_translate_core.sv */
// path from the accepting edge to result valid: queue slot, 5 stages, output reg
// throughput: one item per cycle; the multiply pipeline advances whenever the output
// register is free or being taken
// reset: synchronous, active high; clears queue pointers and count, stage valid bits and output valid bit only
module point_rotate_scale_translate_core (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic signed [31:0]              req_point_x,
   input  logic signed [31:0]              req_point_y,
   input  logic [prst_pkg::ANGLE_BITS-1:0] req_rot_angle,
   input  logic signed [31:0]              req_scale_x,
   input  logic signed [31:0]              req_scale_y,
   input  logic signed [31:0]              req_offset_x,
   input  logic signed [31:0]              req_offset_y,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic signed [31:0]              rsp_result_x,
   output logic signed [31:0]              rsp_result_y,
   output logic                            rsp_overflow
);
   import prst_pkg::*;

   logic            q_valid;
   logic            q_pop;
   queue_entry_type q_entry;

   prst_front u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_point_x   (req_point_x),
      .req_point_y   (req_point_y),
      .req_rot_angle (req_rot_angle),
      .req_scale_x   (req_scale_x),
      .req_scale_y   (req_scale_y),
      .req_offset_x  (req_offset_x),
      .req_offset_y  (req_offset_y),
      .q_valid       (q_valid),
      .q_entry       (q_entry),
      .q_pop         (q_pop)
   );

   prst_back u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_entry      (q_entry),
      .q_pop        (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_result_x (rsp_result_x),
      .rsp_result_y (rsp_result_y),
      .rsp_overflow (rsp_overflow)
   );

endmodule

/* verif/tb.sv */
module tb;
   import prst_pkg::*;

   typedef struct {
      logic signed [31:0] rx;
      logic signed [31:0] ry;
      logic               ov;
   } xform_result_type;

   class point_scoreboard;
      longint           sin_tab [0:QUARTER-1];
      longint           cos_tab [0:QUARTER-1];
      xform_result_type pending_results[$];
      int               mismatches;

      function new();
         longint unsigned t, t2, st, ct, rs, rc;
         longint          s, c;
         mismatches = 0;
         for (int r = 0; r < QUARTER; r++) begin
            t  = (longint'(r) * 64'd1686629713) >> QUAD_BITS;
            t2 = (t * t) >> 30;
            st = t;
            ct = 64'd1 << 30;
            s  = st;
            c  = ct;
            for (int k = 1; k <= 8; k++) begin
               st = ((st * t2) >> 30) / ((2 * k) * (2 * k + 1));
               ct = ((ct * t2) >> 30) / ((2 * k - 1) * (2 * k));
               if (k % 2 == 1) begin
                  s = s - longint'(st);
                  c = c - longint'(ct);
               end else begin
                  s = s + longint'(st);
                  c = c + longint'(ct);
               end
            end
            if (s < 0) s = 0;
            if (c < 0) c = 0;
            rs = (longint'(s) + 8192) >> 14;
            rc = (longint'(c) + 8192) >> 14;
            sin_tab[r] = (rs > 65536) ? 65536 : rs;
            cos_tab[r] = (rc > 65536) ? 65536 : rc;
         end
      endfunction

      function automatic logic signed [31:0] clamp(logic signed [95:0] v, ref logic ov);
         if (v > 96'sd2147483647) begin
            ov = 1'b1;
            return 32'sh7fffffff;
         end else if (v < -96'sd2147483648) begin
            ov = 1'b1;
            return 32'sh80000000;
         end
         return v[31:0];
      endfunction

      function void note_point(logic signed [31:0] x, logic signed [31:0] y,
                               logic [ANGLE_BITS-1:0] ang,
                               logic signed [31:0] kx, logic signed [31:0] ky,
                               logic signed [31:0] ox, logic signed [31:0] oy);
         longint             s, c, sn, cs, xr, yr;
         logic signed [95:0] wx, wy, px, py;
         xform_result_type   e;
         s = sin_tab[ang[QUAD_BITS-1:0]];
         c = cos_tab[ang[QUAD_BITS-1:0]];
         case (ang[ANGLE_BITS-1 -: 2])
            QUAD_0: begin sn = s;  cs = c;  end
            QUAD_1: begin sn = c;  cs = -s; end
            QUAD_2: begin sn = -s; cs = -c; end
            default: begin sn = -c; cs = s; end
         endcase
         xr = ((longint'(x) * cs) >>> 16) + ((longint'(y) * sn) >>> 16);
         yr = ((longint'(x) * -sn) >>> 16) + ((longint'(y) * cs) >>> 16);
         wx = xr;
         wy = yr;
         px = ((wx * 96'(kx)) >>> 16) + 96'(ox);
         py = ((wy * 96'(ky)) >>> 16) + 96'(oy);
         e.ov = 1'b0;
         e.rx = clamp(px, e.ov);
         e.ry = clamp(py, e.ov);
         pending_results.push_back(e);
      endfunction

      function void check_result(logic signed [31:0] rx, logic signed [31:0] ry, logic ov);
         xform_result_type e;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result x=%0d y=%0d ov=%0b", rx, ry, ov);
            return;
         end
         e = pending_results.pop_front();
         if (e.rx !== rx || e.ry !== ry || e.ov !== ov) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch: exp x=%0d y=%0d ov=%0b got x=%0d y=%0d ov=%0b",
                        e.rx, e.ry, e.ov, rx, ry, ov);
         end
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic signed [31:0]    req_point_x = '0;
   logic signed [31:0]    req_point_y = '0;
   logic [ANGLE_BITS-1:0] req_rot_angle = '0;
   logic signed [31:0]    req_scale_x = '0;
   logic signed [31:0]    req_scale_y = '0;
   logic signed [31:0]    req_offset_x = '0;
   logic signed [31:0]    req_offset_y = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b1;
   logic signed [31:0]    rsp_result_x;
   logic signed [31:0]    rsp_result_y;
   logic                  rsp_overflow;

   point_scoreboard sb = new();
   bit  steady_flow = 0;
   bit  long_hold = 0;
   int  quiet_cycles = 0;

   point_rotate_scale_translate_core u_dut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall)
         sb.note_point(req_point_x, req_point_y, req_rot_angle, req_scale_x, req_scale_y,
                       req_offset_x, req_offset_y);
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_result(rsp_result_x, rsp_result_y, rsp_overflow);
   end

   // watchdog on cycles without any handshake
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= 3000) begin
         $display("point_rotate_scale_translate_core regression: fail");
         $finish;
      end
   end

   // result side
   initial begin
      int gap;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         if (long_hold) begin
            rsp_stall <= 1'b1;
            repeat (120) @(posedge clock);
            long_hold = 0;
         end
         gap = steady_flow ? 0 : $urandom_range(0, 8);
         if (gap > 0) begin
            rsp_stall <= 1'b1;
            repeat (gap) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   function automatic logic signed [31:0] pick_word();
      logic [31:0] w;
      w = $urandom;
      case ($urandom_range(0, 7))
         0: return w;
         1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
         2, 3: return {{12{w[19]}}, w[19:0]};
         default: return {{8{w[23]}}, w[23:0]};
      endcase
   endfunction

   function automatic logic signed [31:0] pick_scale();
      logic [31:0] w;
      w = $urandom;
      if ($urandom_range(0, 3) == 0) return w;
      return {{13{w[18]}}, w[18:0]};
   endfunction

   task automatic send_point(logic signed [31:0] x, logic signed [31:0] y,
                             logic [ANGLE_BITS-1:0] ang,
                             logic signed [31:0] kx, logic signed [31:0] ky,
                             logic signed [31:0] ox, logic signed [31:0] oy);
      int gap;
      gap = steady_flow ? 0 : $urandom_range(0, 8);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_point_x   <= x;
      req_point_y   <= y;
      req_rot_angle <= ang;
      req_scale_x   <= kx;
      req_scale_y   <= ky;
      req_offset_x  <= ox;
      req_offset_y  <= oy;
      req_valid     <= 1'b1;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic send_random_point();
      send_point(pick_word(), pick_word(), ANGLE_BITS'($urandom), pick_scale(), pick_scale(),
                 pick_word(), pick_word());
   endtask

   task automatic wait_drained();
      while (sb.pending_results.size() != 0) @(posedge clock);
   endtask

   localparam logic signed [31:0] ONE  = 32'sh00010000;
   localparam logic signed [31:0] MAXV = 32'sh7fffffff;
   localparam logic signed [31:0] MINV = 32'sh80000000;

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // quadrant boundaries and identity
      send_point(ONE, 2 * ONE, 12'd0, ONE, ONE, 0, 0);
      send_point(ONE, 2 * ONE, 12'd1024, ONE, ONE, 0, 0);
      send_point(ONE, 2 * ONE, 12'd2048, ONE, ONE, 0, 0);
      send_point(ONE, 2 * ONE, 12'd3072, ONE, ONE, 0, 0);
      send_point(ONE, 2 * ONE, 12'd1023, ONE, ONE, 0, 0);
      send_point(-ONE, ONE, 12'd4095, ONE, ONE, 0, 0);
      send_point(-3, -5, 12'd512, ONE, ONE, 0, 0);
      // extremes and saturation
      send_point(MAXV, MAXV, 12'd0, MAXV, MAXV, MAXV, MAXV);
      send_point(MINV, MINV, 12'd2048, MINV, MINV, MINV, MINV);
      send_point(MINV, MAXV, 12'd1536, MAXV, MINV, MAXV, MINV);
      send_point(MAXV, MINV, 12'd3584, MINV, MAXV, MINV, MAXV);
      send_point(ONE, 0, 12'd0, ONE, ONE, MAXV, MINV);
      send_point(ONE, ONE, 12'd0, ONE, ONE, MAXV, MINV);
      send_point(-ONE, -ONE, 12'd0, ONE, ONE, MINV, MAXV);
      send_point(MAXV, MAXV, 12'd2560, 0, 0, 0, 0);
      send_point(0, 0, 12'd1000, MAXV, MINV, 32'sh12345678, -32'sh12345678);
      send_point(MINV, MINV, 12'd512, MINV, MINV, 0, 0);
      send_point(-1, -1, 12'd3000, -1, -1, -1, -1);
      send_point(32'sh55555555, 32'shaaaaaaaa, 12'haaa, 32'shaaaaaaaa, 32'sh55555555,
                 32'sh55555555, 32'shaaaaaaaa);
      for (int i = 0; i < 1830; i++) begin
         if (i == 400) steady_flow = 1;
         if (i == 600) steady_flow = 0;
         if (i == 1000) begin
            long_hold = 1;
            steady_flow = 1;
         end
         if (i == 1040) steady_flow = 0;
         if (i == 1400) begin
            req_valid <= 1'b0;
            wait_drained();
            @(posedge clock);
         end
         send_random_point();
      end
      req_valid <= 1'b0;
      wait_drained();
      repeat (20) @(posedge clock);
      if (sb.mismatches == 0 && sb.pending_results.size() == 0)
         $display("point_rotate_scale_translate_core regression: pass");
      else
         $display("point_rotate_scale_translate_core regression: fail");
      $finish;
   end

endmodule
